>>> src/software_timer_bank_top_assert.svh
// assertion macros for the timer bank checker
`ifndef SOFTWARE_TIMER_BANK_TOP_ASSERT_SVH
`define SOFTWARE_TIMER_BANK_TOP_ASSERT_SVH

// same-cycle implication
`define STB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/stb_pkg.sv
`timescale 1ns / 1ps
package stb_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int MAX_FIRES     = 16;
	localparam int FIRE_CW       = $clog2(MAX_FIRES + 1);
	localparam int TICK_W        = 32;
	localparam int OPC_W         = 3;
	localparam int ID_W          = 4;
	localparam int HALF_W        = 16;

	typedef enum logic [OPC_W-1:0] {
		OP_CREATE    = 3'd0,
		OP_START     = 3'd1,
		OP_STOP      = 3'd2,
		OP_REMOVE    = 3'd3,
		OP_QUERY     = 3'd4,
		OP_TICK      = 3'd5,
		OP_SERVICE   = 3'd6,
		OP_READ_TICK = 3'd7
	} opc_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN_RD,
		ST_SCAN_WR,
		ST_DONE
	} st_t;

	typedef enum logic {
		ALU_MUL,
		ALU_DEC
	} alu_op_t;

	typedef struct packed {
		alu_op_t            op;
		logic [TICK_W-1:0]  opa;
		logic [HALF_W-1:0]  opb;
	} alu_req_t;

endpackage

>>> src/stb_if.sv
`timescale 1ns / 1ps
interface stb_in_if;
	import stb_pkg::*;
	logic              valid;
	logic              ready;
	logic [OPC_W-1:0]  opcode;
	logic [ID_W-1:0]   timer_id;
	logic [HALF_W-1:0] scale;
	logic [HALF_W-1:0] interval;
	logic              auto_reload;

	modport source (output valid, opcode, timer_id, scale, interval, auto_reload,
		input ready);
	modport sink (input valid, opcode, timer_id, scale, interval, auto_reload,
		output ready);
endinterface

interface stb_out_if;
	import stb_pkg::*;
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   slot_id;
	logic              status;
	logic              running;
	logic              fired;
	logic [TICK_W-1:0] tick_total;
	logic              last;

	modport source (output valid, slot_id, status, running, fired, tick_total, last,
		input ready);
	modport sink (input valid, slot_id, status, running, fired, tick_total, last,
		output ready);
endinterface

>>> src/stb_ram.sv
`timescale 1ns / 1ps
module stb_ram #(
	parameter int DEPTH = stb_pkg::NUM_SLOTS_DEF,
	parameter int AW    = 4,
	parameter int DW    = stb_pkg::TICK_W
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

>>> src/stb_alu.sv
`timescale 1ns / 1ps
module stb_alu (
	input  stb_pkg::alu_req_t          req,
	output logic [stb_pkg::TICK_W-1:0] res,
	output logic                       gt1
);
	import stb_pkg::*;

	logic [TICK_W-1:0] prod;
	logic [TICK_W-1:0] dec;

	assign prod = {{(TICK_W-HALF_W){1'b0}}, req.opa[HALF_W-1:0]}
		* {{(TICK_W-HALF_W){1'b0}}, req.opb};
	assign dec  = req.opa - TICK_W'(1);
	assign gt1  = req.opa > TICK_W'(1);

	always_comb begin
		case (req.op)
			ALU_MUL: res = prod;
			ALU_DEC: res = dec;
			default: res = dec;
		endcase
	end
endmodule

>>> src/software_timer_bank_top.sv
`timescale 1ns / 1ps
// channel  dir  words
// cmd      in   opcode, timer_id, scale, interval, auto_reload
// rsp      out  slot_id, status, running, fired, tick_total, last
//
// start, stop, remove, query, read tick count: exec state, then done state with the result
// create: walks the used flags one slot per cycle until a free slot or the last slot
// tick and service: a time store read state and a write-back state per slot, tick writing
// back through the shared decrement unit; service stops at MAX_FIRES fires; stalls on rsp
// reset clears all flags and the tick counter at once; cmd is taken only when idle
module software_timer_bank_top #(
	parameter int NUM_SLOTS = stb_pkg::NUM_SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	stb_in_if.sink    cmd,
	stb_out_if.source rsp
);
	import stb_pkg::*;

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int IW = (SW + 1 > ID_W) ? SW + 1 : ID_W;

	st_t                  state_q, state_d;
	opc_t                 op_q;
	logic [ID_W-1:0]      id_q;
	logic [HALF_W-1:0]    scale_q;
	logic [HALF_W-1:0]    ival_q;
	logic                 reload_q;

	logic [NUM_SLOTS-1:0] used_q;
	logic [NUM_SLOTS-1:0] run_q;
	logic [NUM_SLOTS-1:0] rdy_q;
	logic [SW-1:0]        cnt_q;
	logic [FIRE_CW-1:0]   nfire_q;
	logic [TICK_W-1:0]    tick_q;

	logic [ID_W-1:0]      res_slot_q;
	logic                 res_status_q;
	logic                 res_running_q;
	logic                 res_fired_q;

	logic                 ovalid_q;
	logic [ID_W-1:0]      o_slot_q;
	logic                 o_status_q;
	logic                 o_running_q;
	logic                 o_fired_q;
	logic [TICK_W-1:0]    o_tick_q;
	logic                 o_last_q;

	logic                 accept;
	logic                 out_free;
	logic [IW-1:0]        id_w;
	logic                 id_ok;
	logic [SW-1:0]        idi;
	logic                 scan_end;
	logic                 cur_act;
	logic                 fire_cond;

	logic                 emit;
	logic                 emit_last;
	logic                 adv;
	logic                 fire;
	logic                 found;
	logic                 full;

	alu_req_t             alu_req;
	logic [TICK_W-1:0]    alu_res;
	logic                 alu_gt1;

	logic                 start_ok;
	logic                 rem_we;
	logic [SW-1:0]        rem_waddr;
	logic [TICK_W-1:0]    rem_wdata;
	logic [TICK_W-1:0]    rem_rd;
	logic [TICK_W-1:0]    rld_wdata;
	logic [TICK_W-1:0]    rld_rd;
	logic                 rld_nz;

	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !ovalid_q || rsp.ready;
	assign id_w      = IW'(id_q);
	assign id_ok     = id_w < IW'(NUM_SLOTS);
	assign idi       = id_w[SW-1:0];
	assign scan_end  = cnt_q == SW'(NUM_SLOTS - 1);
	assign cur_act   = used_q[cnt_q] && run_q[cnt_q];
	assign fire_cond = cur_act && rdy_q[cnt_q];
	assign rld_nz    = rld_rd != '0;
	assign start_ok  = (state_q == ST_EXEC) && (op_q == OP_START) && id_ok && used_q[idi];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		emit_last = 1'b0;
		adv       = 1'b0;
		fire      = 1'b0;
		found     = 1'b0;
		full      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (op_q)
					OP_CREATE, OP_TICK, OP_SERVICE: state_d = ST_SCAN_RD;
					default:                        state_d = ST_DONE;
				endcase
			end
			ST_SCAN_RD: begin
				if (op_q == OP_CREATE) begin
					if (!used_q[cnt_q]) begin
						found   = 1'b1;
						state_d = ST_DONE;
					end else if (scan_end) begin
						full    = 1'b1;
						state_d = ST_DONE;
					end else begin
						adv = 1'b1;
					end
				end else begin
					state_d = ST_SCAN_WR;
				end
			end
			ST_SCAN_WR: begin
				if (op_q == OP_SERVICE) begin
					if (!(fire_cond && res_fired_q && !out_free)) begin
						fire = fire_cond;
						emit = fire_cond && res_fired_q;
						if ((fire_cond && nfire_q == FIRE_CW'(MAX_FIRES - 1)) || scan_end) begin
							state_d = ST_DONE;
						end else begin
							adv     = 1'b1;
							state_d = ST_SCAN_RD;
						end
					end
				end else if (scan_end) begin
					state_d = ST_DONE;
				end else begin
					adv     = 1'b1;
					state_d = ST_SCAN_RD;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= opc_t'(cmd.opcode);
			id_q     <= cmd.timer_id;
			scale_q  <= cmd.scale;
			ival_q   <= cmd.interval;
			reload_q <= cmd.auto_reload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			nfire_q       <= '0;
			tick_q        <= '0;
			res_slot_q    <= '0;
			res_status_q  <= 1'b0;
			res_running_q <= 1'b0;
			res_fired_q   <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q         <= '0;
				nfire_q       <= '0;
				res_slot_q    <= '0;
				res_status_q  <= 1'b0;
				res_running_q <= 1'b0;
				res_fired_q   <= 1'b0;
			end else begin
				if (adv) begin
					cnt_q <= cnt_q + SW'(1);
				end
				if (found || fire) begin
					res_slot_q <= ID_W'(cnt_q);
				end
				if (fire) begin
					res_fired_q <= 1'b1;
					nfire_q     <= nfire_q + FIRE_CW'(1);
				end
				if (full) begin
					res_status_q <= 1'b1;
				end
				if (state_q == ST_EXEC && op_q == OP_QUERY) begin
					res_running_q <= id_ok && run_q[idi];
				end
			end
			if (state_q == ST_EXEC && op_q == OP_TICK) begin
				tick_q <= tick_q + TICK_W'(1);
			end
		end
	end

	// slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			run_q  <= '0;
			rdy_q  <= '0;
		end else begin
			if (start_ok) begin
				run_q[idi] <= 1'b1;
			end
			if (state_q == ST_EXEC && id_ok && (op_q == OP_STOP || op_q == OP_REMOVE)) begin
				run_q[idi] <= 1'b0;
				rdy_q[idi] <= 1'b0;
				if (op_q == OP_REMOVE) begin
					used_q[idi] <= 1'b0;
				end
			end
			if (found) begin
				used_q[cnt_q] <= 1'b1;
			end
			if (state_q == ST_SCAN_WR && op_q == OP_TICK && cur_act && !alu_gt1) begin
				rdy_q[cnt_q] <= 1'b1;
			end
			if (fire) begin
				rdy_q[cnt_q] <= 1'b0;
				run_q[cnt_q] <= rld_nz;
			end
		end
	end

	always_comb begin
		alu_req.opb = ival_q;
		if (state_q == ST_EXEC) begin
			alu_req.op  = ALU_MUL;
			alu_req.opa = {{(TICK_W-HALF_W){1'b0}}, scale_q};
		end else begin
			alu_req.op  = ALU_DEC;
			alu_req.opa = rem_rd;
		end
	end

	stb_alu u_alu (
		.req (alu_req),
		.res (alu_res),
		.gt1 (alu_gt1)
	);

	assign rem_we    = start_ok
		|| (state_q == ST_SCAN_WR && op_q == OP_TICK && cur_act && alu_gt1)
		|| (fire && rld_nz);
	assign rem_waddr = (state_q == ST_EXEC) ? idi : cnt_q;
	assign rem_wdata = fire ? rld_rd : alu_res;
	assign rld_wdata = reload_q ? alu_res : '0;

	stb_ram #(
		.DEPTH (NUM_SLOTS),
		.AW    (SW),
		.DW    (TICK_W)
	) u_rem (
		.clk   (clk),
		.we    (rem_we),
		.waddr (rem_waddr),
		.wdata (rem_wdata),
		.raddr (cnt_q),
		.rdata (rem_rd)
	);

	stb_ram #(
		.DEPTH (NUM_SLOTS),
		.AW    (SW),
		.DW    (TICK_W)
	) u_rld (
		.clk   (clk),
		.we    (start_ok),
		.waddr (idi),
		.wdata (rld_wdata),
		.raddr (cnt_q),
		.rdata (rld_rd)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			o_slot_q    <= res_slot_q;
			o_status_q  <= res_status_q;
			o_running_q <= res_running_q;
			o_fired_q   <= res_fired_q;
			o_tick_q    <= tick_q;
			o_last_q    <= emit_last;
		end
	end

	assign cmd.ready      = state_q == ST_IDLE;
	assign rsp.valid      = ovalid_q;
	assign rsp.slot_id    = o_slot_q;
	assign rsp.status     = o_status_q;
	assign rsp.running    = o_running_q;
	assign rsp.fired      = o_fired_q;
	assign rsp.tick_total = o_tick_q;
	assign rsp.last       = o_last_q;
endmodule

>>> src/stb_chk.sv
`timescale 1ns / 1ps
`include "software_timer_bank_top_assert.svh"
module stb_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [stb_pkg::ID_W-1:0]   rsp_slot_id,
	input logic                       rsp_status,
	input logic                       rsp_running,
	input logic                       rsp_fired,
	input logic                       rsp_last
);
	`STB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped while stalled")
	`STB_ASSERT_NOW(a_nonlast_fire, rsp_valid && !rsp_last, rsp_fired, "non-final word is not a fire")
	`STB_ASSERT_NOW(a_full_clean, rsp_valid && rsp_status, rsp_slot_id == '0 && !rsp_fired, "full status with slot or fire")
	`STB_ASSERT_NOW(a_fire_clean, rsp_valid && rsp_fired, !rsp_running && !rsp_status, "fire word carries query or status")
endmodule

bind software_timer_bank_top stb_chk u_stb_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_slot_id (rsp.slot_id),
	.rsp_status  (rsp.status),
	.rsp_running (rsp.running),
	.rsp_fired   (rsp.fired),
	.rsp_last    (rsp.last)
);

>>> bench/software_timer_bank_top_tb.sv
`timescale 1ns / 1ps
module software_timer_bank_top_tb;
	import stb_pkg::*;

	localparam int SLOTS       = NUM_SLOTS_DEF;
	localparam int HOLD_AT     = 40;
	localparam int HOLD_CYCLES = 200;
	localparam int IDLE_PCT    = 27;
	localparam int RANDOM_CMDS = 60;

	typedef struct {
		bit                drain;
		opc_t              op;
		logic [ID_W-1:0]   timer_id;
		logic [HALF_W-1:0] scale;
		logic [HALF_W-1:0] interval;
		logic              auto_reload;
	} timer_cmd_t;

	typedef struct packed {
		logic [ID_W-1:0]   slot_id;
		logic              status;
		logic              running;
		logic              fired;
		logic [TICK_W-1:0] tick_total;
		logic              last;
	} timer_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	stb_in_if  cmd_ch ();
	stb_out_if rsp_ch ();

	software_timer_bank_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch.sink),
		.rsp    (rsp_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected timer state
	bit                slot_in_use [SLOTS];
	bit                slot_armed  [SLOTS];
	bit                slot_due    [SLOTS];
	logic [TICK_W-1:0] ticks_left  [SLOTS];
	logic [TICK_W-1:0] period_ticks[SLOTS];
	logic [TICK_W-1:0] tick_count;

	timer_cmd_t cmd_backlog[$];
	timer_rsp_t pending_responses[$];
	timer_cmd_t next_cmd;
	timer_cmd_t accepted_cmd;
	timer_rsp_t got_rsp;
	timer_rsp_t want_rsp;

	int errors          = 0;
	int commands_sent   = 0;
	int results_checked = 0;
	int fires_expected  = 0;
	int full_creates    = 0;
	int widest_service  = 0;
	int hold_left       = 0;
	bit hold_done       = 1'b0;

	task automatic apply_timer_command(input timer_cmd_t c);
		timer_rsp_t        r;
		int                i;
		int                fires;
		logic [TICK_W-1:0] span;
		r     = '0;
		fires = 0;
		r.last = 1'b1;
		case (c.op)
			OP_CREATE: begin
				for (i = 0; i < SLOTS; i++)
					if (!slot_in_use[i])
						break;
				if (i < SLOTS) begin
					slot_in_use[i] = 1'b1;
					r.slot_id = i[ID_W-1:0];
				end else begin
					r.status = 1'b1;
					full_creates++;
				end
			end
			OP_START: begin
				if (slot_in_use[c.timer_id]) begin
					span = c.scale * c.interval;
					ticks_left[c.timer_id]   = span;
					period_ticks[c.timer_id] = c.auto_reload ? span : '0;
					slot_armed[c.timer_id]   = 1'b1;
				end
			end
			OP_STOP: begin
				slot_armed[c.timer_id]   = 1'b0;
				period_ticks[c.timer_id] = '0;
				slot_due[c.timer_id]     = 1'b0;
			end
			OP_REMOVE: begin
				slot_in_use[c.timer_id]  = 1'b0;
				slot_armed[c.timer_id]   = 1'b0;
				slot_due[c.timer_id]     = 1'b0;
				ticks_left[c.timer_id]   = '0;
				period_ticks[c.timer_id] = '0;
			end
			OP_QUERY: r.running = slot_armed[c.timer_id];
			OP_TICK: begin
				for (i = 0; i < SLOTS; i++) begin
					if (!slot_in_use[i] || !slot_armed[i])
						continue;
					if (ticks_left[i] > 1)
						ticks_left[i] = ticks_left[i] - 1;
					else
						slot_due[i] = 1'b1;
				end
				tick_count = tick_count + 1;
			end
			OP_SERVICE: begin
				for (i = 0; i < SLOTS && fires < MAX_FIRES; i++) begin
					if (!slot_in_use[i] || !slot_armed[i] || !slot_due[i])
						continue;
					slot_due[i]   = 1'b0;
					slot_armed[i] = 1'b0;
					if (period_ticks[i] != 0) begin
						ticks_left[i] = period_ticks[i];
						slot_armed[i] = 1'b1;
					end
					pending_responses.push_back('{slot_id: i[ID_W-1:0], status: 1'b0,
						running: 1'b0, fired: 1'b1, tick_total: tick_count, last: 1'b0});
					fires++;
				end
				fires_expected += fires;
				if (fires > widest_service)
					widest_service = fires;
			end
			default: ;
		endcase
		r.tick_total = tick_count;
		if (c.op == OP_SERVICE && fires != 0)
			pending_responses[pending_responses.size() - 1].last = 1'b1;
		else
			pending_responses.push_back(r);
	endtask

	task automatic check_field(input string label, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s expected %0h actual %0h", $time, label, want, got);
		end
	endtask

	function automatic void push_cmd(input opc_t op, input int id, input int scale,
		input int interval, input bit reload);
		timer_cmd_t c;
		c.drain       = 1'b0;
		c.op          = op;
		c.timer_id    = id[ID_W-1:0];
		c.scale       = scale[HALF_W-1:0];
		c.interval    = interval[HALF_W-1:0];
		c.auto_reload = reload;
		cmd_backlog.push_back(c);
	endfunction

	function automatic void push_drain();
		timer_cmd_t c;
		c.drain       = 1'b1;
		c.op          = OP_QUERY;
		c.timer_id    = '0;
		c.scale       = '0;
		c.interval    = '0;
		c.auto_reload = 1'b0;
		cmd_backlog.push_back(c);
	endfunction

	function automatic int pick_len();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 4) : $urandom_range(0, 65535);
	endfunction

	// the block only updates state through accepted words, so the prediction runs here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid       <= 1'b0;
			cmd_ch.opcode      <= OP_QUERY;
			cmd_ch.timer_id    <= '0;
			cmd_ch.scale       <= '0;
			cmd_ch.interval    <= '0;
			cmd_ch.auto_reload <= 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				accepted_cmd.drain       = 1'b0;
				accepted_cmd.op          = opc_t'(cmd_ch.opcode);
				accepted_cmd.timer_id    = cmd_ch.timer_id;
				accepted_cmd.scale       = cmd_ch.scale;
				accepted_cmd.interval    = cmd_ch.interval;
				accepted_cmd.auto_reload = cmd_ch.auto_reload;
				apply_timer_command(accepted_cmd);
				commands_sent++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (cmd_backlog.size() != 0 && cmd_backlog[0].drain) begin
					if (pending_responses.size() == 0)
						void'(cmd_backlog.pop_front());
					cmd_ch.valid <= 1'b0;
				end else if (cmd_backlog.size() != 0 && ((commands_sent >= 60 &&
					commands_sent < 95) || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_cmd = cmd_backlog.pop_front();
					cmd_ch.valid       <= 1'b1;
					cmd_ch.opcode      <= next_cmd.op;
					cmd_ch.timer_id    <= next_cmd.timer_id;
					cmd_ch.scale       <= next_cmd.scale;
					cmd_ch.interval    <= next_cmd.interval;
					cmd_ch.auto_reload <= next_cmd.auto_reload;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_rsp = '{slot_id: rsp_ch.slot_id, status: rsp_ch.status,
					running: rsp_ch.running, fired: rsp_ch.fired,
					tick_total: rsp_ch.tick_total, last: rsp_ch.last};
				if (pending_responses.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected response word expected none actual %h",
						$time, got_rsp);
				end else begin
					want_rsp = pending_responses.pop_front();
					check_field("slot_id", want_rsp.slot_id, got_rsp.slot_id);
					check_field("status", want_rsp.status, got_rsp.status);
					check_field("running", want_rsp.running, got_rsp.running);
					check_field("fired", want_rsp.fired, got_rsp.fired);
					check_field("tick_total", want_rsp.tick_total, got_rsp.tick_total);
					check_field("last", want_rsp.last, got_rsp.last);
				end
				results_checked++;
			end
			// one long back-pressure window so the response word stays pending and stalls cmd
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!hold_done && results_checked >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= (results_checked >= 70 && results_checked < 110) ||
					$urandom_range(0, 99) >= IDLE_PCT;
			end
		end
	end

	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int n;
		int id;
		cmd_ch.valid       = 1'b0;
		cmd_ch.opcode      = OP_QUERY;
		cmd_ch.timer_id    = '0;
		cmd_ch.scale       = '0;
		cmd_ch.interval    = '0;
		cmd_ch.auto_reload = 1'b0;
		rsp_ch.ready       = 1'b0;
		arst_n             = 1'b0;
		for (id = 0; id < SLOTS; id++) begin
			slot_in_use[id]  = 1'b0;
			slot_armed[id]   = 1'b0;
			slot_due[id]     = 1'b0;
			ticks_left[id]   = '0;
			period_ticks[id] = '0;
		end
		tick_count = '0;

		// directed: free-slot commands, empty service, zero and max length, reload
		push_cmd(OP_QUERY, 0, 0, 0, 0);
		push_cmd(OP_START, 5, 3, 2, 1);
		push_cmd(OP_STOP, 15, 0, 0, 0);
		push_cmd(OP_REMOVE, 9, 0, 0, 0);
		push_cmd(OP_SERVICE, 0, 0, 0, 0);
		push_cmd(OP_READ_TICK, 0, 0, 0, 0);
		push_cmd(OP_CREATE, 0, 0, 0, 0);
		push_cmd(OP_CREATE, 0, 0, 0, 0);
		push_cmd(OP_CREATE, 0, 0, 0, 0);
		push_cmd(OP_START, 0, 0, 65535, 1);
		push_cmd(OP_START, 1, 65535, 65535, 1);
		push_cmd(OP_START, 2, 1, 2, 1);
		push_cmd(OP_QUERY, 1, 0, 0, 0);
		push_cmd(OP_TICK, 0, 0, 0, 0);
		push_cmd(OP_TICK, 0, 0, 0, 0);
		push_cmd(OP_SERVICE, 0, 0, 0, 0);
		push_cmd(OP_QUERY, 2, 0, 0, 0);
		push_cmd(OP_STOP, 1, 0, 0, 0);
		push_cmd(OP_QUERY, 1, 0, 0, 0);
		push_cmd(OP_REMOVE, 1, 0, 0, 0);
		push_cmd(OP_CREATE, 0, 0, 0, 0);
		push_cmd(OP_READ_TICK, 15, 65535, 65535, 1);
		push_drain();

		// fill the table past full, expire every slot at once
		for (id = 0; id < SLOTS + 2; id++)
			push_cmd(OP_CREATE, 0, 0, 0, 0);
		for (id = 0; id < SLOTS; id++)
			push_cmd(OP_START, id, 1, 1, $urandom_range(0, 1));
		push_cmd(OP_TICK, 0, 0, 0, 0);
		push_cmd(OP_SERVICE, 0, 0, 0, 0);
		push_cmd(OP_TICK, 0, 0, 0, 0);
		push_cmd(OP_SERVICE, 0, 0, 0, 0);

		for (n = 0; n < RANDOM_CMDS; n++) begin
			if (n == 30)
				push_drain();
			case ($urandom_range(0, 19))
				0, 1: push_cmd(OP_CREATE, $urandom_range(0, 15), $urandom, $urandom,
					$urandom_range(0, 1));
				2, 3, 4, 5: push_cmd(OP_START, $urandom_range(0, 15), pick_len(), pick_len(),
					$urandom_range(0, 1));
				6: push_cmd(OP_STOP, $urandom_range(0, 15), $urandom, $urandom,
					$urandom_range(0, 1));
				7: push_cmd(OP_REMOVE, $urandom_range(0, 15), $urandom, $urandom,
					$urandom_range(0, 1));
				8, 9: push_cmd(OP_QUERY, $urandom_range(0, 15), $urandom, $urandom,
					$urandom_range(0, 1));
				10, 11, 12, 13, 14: push_cmd(OP_TICK, $urandom_range(0, 15), $urandom,
					$urandom, $urandom_range(0, 1));
				15, 16, 17: push_cmd(OP_SERVICE, $urandom_range(0, 15), $urandom, $urandom,
					$urandom_range(0, 1));
				default: push_cmd(OP_READ_TICK, $urandom_range(0, 15), $urandom, $urandom,
					$urandom_range(0, 1));
			endcase
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || cmd_ch.valid)
			@(posedge clk);
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (2 * SLOTS + 20) @(posedge clk);

		$display("covered %0d commands and %0d response words: %0d expiries (up to %0d in one",
			commands_sent, results_checked, fires_expected, widest_service);
		$display("service), %0d creates on a full table, ticks counted %0d",
			full_creates, tick_count);
		if (errors == 0 && pending_responses.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/stb_pkg.sv
src/stb_if.sv
src/stb_ram.sv
src/stb_alu.sv
src/software_timer_bank_top.sv
src/stb_chk.sv
bench/software_timer_bank_top_tb.sv
